@@ rtl/core/wbps_pkg.sv @@
// Package for the wildcard byte pattern scan.
// Holds field widths, command codes, reset values and the per-item control struct.
// No dependencies.
package wbps_pkg;

   localparam int PATTERN_MAX_DEFAULT = 64;
   localparam int OFFSET_BITS_DEFAULT = 32;

   localparam int PAT_INDEX_W    = 6;
   localparam int BYTE_W         = 8;
   localparam int LEN_W          = 7;
   localparam int MATCH_OFFSET_W = 32;

   localparam logic CMD_PATTERN = 1'b0;
   localparam logic CMD_DATA    = 1'b1;

   localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 7'd1;

   // Control for the item that leaves the input register this cycle.
   typedef struct packed {
      logic wr_pat;   // write one pattern entry
      logic shift;    // consume one region byte
      logic last;     // that byte closes the region
   } scan_ctl_type;

endpackage

@@ rtl/core/wildcard_byte_pattern_scan.sv @@
// Top level of the wildcard byte pattern scan: input register, length register,
// match array and result register. Depends on wbps_pkg, wbps_match_array, wbps_result.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   cmd, pattern_index/byte/care, data_byte/last
//   rsp_      out        rsp_valid/rsp_stall   found, match_offset
//   csr_      in         csr_wr_en             csr_wr_data (pattern length)
//
// One item per cycle while req_stall is low. An item waits in the input register and its
// result, if any, is loaded into the result register when the item leaves it. Synchronous
// reset clears the match vector, the byte position, the length (to one) and all valid
// flags; pattern entries are not cleared. A stall on rsp_ holds the result and backs up
// into req_stall only once the input register is also full.
module wildcard_byte_pattern_scan #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEFAULT,
   parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [wbps_pkg::PAT_INDEX_W-1:0]      req_pattern_index,
   input  logic [wbps_pkg::BYTE_W-1:0]           req_pattern_byte,
   input  logic                                  req_pattern_care,
   input  logic [wbps_pkg::BYTE_W-1:0]           req_data_byte,
   input  logic                                  req_data_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [wbps_pkg::MATCH_OFFSET_W-1:0]   rsp_match_offset,
   input  logic                                  csr_wr_en,
   input  logic [wbps_pkg::LEN_W-1:0]            csr_wr_data
);
   import wbps_pkg::*;

   localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic                   s1_cmd_ff;
   logic [PAT_INDEX_W-1:0] s1_index_ff;
   logic [BYTE_W-1:0]      s1_pat_byte_ff;
   logic                   s1_care_ff;
   logic [BYTE_W-1:0]      s1_data_ff;
   logic                   s1_last_ff;
   logic [LEN_W-1:0]       length_ff;
   logic [31:0]            len_clamped;
   logic [LEN_BITS-1:0]    used_len;
   logic                   advance;
   logic                   req_take;
   logic                   hit;
   scan_ctl_type           ctl;

   // The input register drains whenever the result register is free or emptying.
   assign advance   = s1_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         length_ff   <= PATTERN_LENGTH_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_wr_en) begin
            length_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff      <= req_cmd;
         s1_index_ff    <= req_pattern_index;
         s1_pat_byte_ff <= req_pattern_byte;
         s1_care_ff     <= req_pattern_care;
         s1_data_ff     <= req_data_byte;
         s1_last_ff     <= req_data_last;
      end
   end

   // A length of zero behaves as one; lengths past the store depth are capped.
   always_comb begin
      len_clamped = 32'(length_ff);
      if (len_clamped == 32'd0) begin
         len_clamped = 32'd1;
      end else if (len_clamped > 32'(PATTERN_MAX)) begin
         len_clamped = 32'(PATTERN_MAX);
      end
   end
   assign used_len = LEN_BITS'(len_clamped);

   assign ctl.wr_pat = advance && (s1_cmd_ff == CMD_PATTERN);
   assign ctl.shift  = advance && (s1_cmd_ff == CMD_DATA);
   assign ctl.last   = s1_last_ff;

   wbps_match_array #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_BITS    (LEN_BITS)
   ) u_match_array (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .pattern_index (s1_index_ff),
      .pattern_byte  (s1_pat_byte_ff),
      .pattern_care  (s1_care_ff),
      .data_byte     (s1_data_ff),
      .used_len      (used_len),
      .hit           (hit)
   );

   wbps_result #(
      .OFFSET_BITS (OFFSET_BITS),
      .LEN_BITS    (LEN_BITS)
   ) u_result (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .hit              (hit),
      .used_len         (used_len),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset)
   );

endmodule

@@ rtl/core/wbps_match_array.sv @@
// Pattern entries and the shift-and partial match vector, one cell per position.
// Depends on wbps_pkg.
module wbps_match_array #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEFAULT,
   parameter int LEN_BITS    = $clog2(PATTERN_MAX + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wbps_pkg::scan_ctl_type              ctl,
   input  logic [wbps_pkg::PAT_INDEX_W-1:0]    pattern_index,
   input  logic [wbps_pkg::BYTE_W-1:0]         pattern_byte,
   input  logic                                pattern_care,
   input  logic [wbps_pkg::BYTE_W-1:0]         data_byte,
   input  logic [LEN_BITS-1:0]                 used_len,
   output logic                                hit
);
   import wbps_pkg::*;

   localparam int IDX_BITS = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic [BYTE_W-1:0]      pat_ff [PATTERN_MAX];
   logic                   care_ff [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] vec_ff;
   logic [PATTERN_MAX-1:0] vec_in;
   logic [PATTERN_MAX-1:0] cell_ok;
   logic [LEN_BITS-1:0]    len_m1;
   logic [IDX_BITS-1:0]    hit_sel;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      always_ff @(posedge clock) begin
         if (ctl.wr_pat && (32'(pattern_index) == k)) begin
            pat_ff[k]  <= pattern_byte;
            care_ff[k] <= pattern_care;
         end
      end

      assign cell_ok[k] = (32'(used_len) > k) && (!care_ff[k] || (pat_ff[k] == data_byte));

      if (k == 0) begin : g_first
         assign vec_in[k] = cell_ok[k];
      end else begin : g_rest
         assign vec_in[k] = vec_ff[k-1] && cell_ok[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff <= '0;
      end else if (ctl.shift) begin
         vec_ff <= ctl.last ? '0 : vec_in;
      end
   end

   // The full match bit is the one at the last position in use.
   assign len_m1  = used_len - LEN_BITS'(1);
   assign hit_sel = IDX_BITS'(len_m1);
   assign hit     = vec_in[hit_sel];

endmodule

@@ rtl/core/wbps_result.sv @@
// Byte position counter, report flag and the result register.
// Depends on wbps_pkg.
module wbps_result #(
   parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT,
   parameter int LEN_BITS    = $clog2(wbps_pkg::PATTERN_MAX_DEFAULT + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wbps_pkg::scan_ctl_type                ctl,
   input  logic                                  hit,
   input  logic [LEN_BITS-1:0]                   used_len,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic [wbps_pkg::MATCH_OFFSET_W-1:0]   rsp_match_offset
);
   import wbps_pkg::*;

   localparam int WIDE_BITS = (OFFSET_BITS > MATCH_OFFSET_W) ? OFFSET_BITS : MATCH_OFFSET_W;

   logic [OFFSET_BITS-1:0]    pos_ff;
   logic [OFFSET_BITS-1:0]    pos_in;
   logic                      reported_ff;
   logic                      reported_in;
   logic                      valid_ff;
   logic                      valid_in;
   logic                      found_ff;
   logic [MATCH_OFFSET_W-1:0] offset_ff;
   logic                      emit;
   logic [LEN_BITS-1:0]       len_m1;
   logic [OFFSET_BITS-1:0]    start_pos;
   logic [WIDE_BITS-1:0]      start_wide;

   assign len_m1     = used_len - LEN_BITS'(1);
   assign start_pos  = pos_ff - OFFSET_BITS'(len_m1);
   assign start_wide = WIDE_BITS'(start_pos);

   // Only the first match of a region is reported; a region without one
   // reports not found on its last byte.
   assign emit = ctl.shift && !reported_ff && (hit || ctl.last);

   always_comb begin
      pos_in      = pos_ff;
      reported_in = reported_ff;
      if (ctl.shift) begin
         if (ctl.last) begin
            pos_in      = '0;
            reported_in = 1'b0;
         end else begin
            pos_in = pos_ff + OFFSET_BITS'(1);
            if (hit) begin
               reported_in = 1'b1;
            end
         end
      end
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         reported_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         reported_ff <= reported_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         found_ff  <= hit;
         offset_ff <= hit ? start_wide[MATCH_OFFSET_W-1:0] : '0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_match_offset = offset_ff;

endmodule

@@ rtl/core/wbps_checker.sv @@
// Port-level checks for the wildcard byte pattern scan, bound to the top level.
// Depends on wbps_pkg and wildcard_byte_pattern_scan.
module wbps_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_stall,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_found,
   input  logic [wbps_pkg::MATCH_OFFSET_W-1:0]   rsp_match_offset
);
   import wbps_pkg::*;

   // A not-found result always carries a zero offset.
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_offset == '0))
      else $error("not-found result with nonzero offset");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // With the result register empty the block always takes the next item.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while no result is waiting");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_match_offset)))
      else $error("stalled result changed");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_match_offset (rsp_match_offset)
);

@@ verif/wildcard_byte_pattern_scan_tb.sv @@
// Self-checking testbench for wildcard_byte_pattern_scan: directed and random regions
// checked by a shift-and scoreboard, with random pacing on both channels.
// Depends on wbps_pkg and the wildcard_byte_pattern_scan RTL.

typedef struct packed {
   logic                          cmd;
   logic [wbps_pkg::PAT_INDEX_W-1:0] pattern_index;
   logic [wbps_pkg::BYTE_W-1:0]   pattern_byte;
   logic                          pattern_care;
   logic [wbps_pkg::BYTE_W-1:0]   data_byte;
   logic                          data_last;
} scan_item_type;

typedef struct packed {
   logic                                found;
   logic [wbps_pkg::MATCH_OFFSET_W-1:0] offset;
} scan_hit_type;

class scan_scoreboard;
   localparam int DEPTH = wbps_pkg::PATTERN_MAX_DEFAULT;

   logic [wbps_pkg::BYTE_W-1:0]         entry_byte [DEPTH];
   logic                                entry_care [DEPTH];
   logic [DEPTH-1:0]                    partial_hits;
   logic [wbps_pkg::MATCH_OFFSET_W-1:0] byte_pos;
   bit                                  hit_reported;
   logic [wbps_pkg::LEN_W-1:0]          length_reg;
   scan_hit_type                        expected_hits [$];
   int unsigned                         errors, regions, matched, misses;

   function new();
      foreach (entry_byte[i]) begin
         entry_byte[i] = '0;
         entry_care[i] = 1'b0;
      end
      length_reg   = wbps_pkg::PATTERN_LENGTH_RESET;
      partial_hits = '0;
      byte_pos     = '0;
      hit_reported = 1'b0;
      errors = 0; regions = 0; matched = 0; misses = 0;
   endfunction

   // Length 0 behaves as 1 and anything above the store depth as the full depth.
   function int unsigned active_length();
      if (length_reg == 0) return 1;
      if (length_reg > DEPTH) return DEPTH;
      return length_reg;
   endfunction

   function void set_length(input logic [wbps_pkg::LEN_W-1:0] value);
      length_reg = value;
   endfunction

   function void note_item(input scan_item_type it);
      int unsigned      n;
      logic [DEPTH-1:0] ok_mask;
      if (it.cmd == wbps_pkg::CMD_PATTERN) begin
         entry_byte[it.pattern_index] = it.pattern_byte;
         entry_care[it.pattern_index] = it.pattern_care;
         return;
      end
      n = active_length();
      for (int k = 0; k < DEPTH; k++)
         ok_mask[k] = (k < n) && (!entry_care[k] || entry_byte[k] == it.data_byte);
      partial_hits = ((partial_hits << 1) | 1) & ok_mask;
      if (!hit_reported && partial_hits[n-1]) begin
         expected_hits.push_back('{found: 1'b1, offset: byte_pos - 32'(n - 1)});
         hit_reported = 1'b1;
         matched++;
      end else if (!hit_reported && it.data_last) begin
         expected_hits.push_back('{found: 1'b0, offset: '0});
         misses++;
      end
      byte_pos++;
      if (it.data_last) begin
         partial_hits = '0;
         byte_pos     = '0;
         hit_reported = 1'b0;
         regions++;
      end
   endfunction

   function void check_result(input logic found, input logic [31:0] offset);
      scan_hit_type want;
      if (expected_hits.size() == 0) begin
         $error("result with nothing expected: found %0d, match_offset %0d", found, offset);
         errors++;
         return;
      end
      want = expected_hits.pop_front();
      if (found !== want.found) begin
         $error("found mismatch: expected %0d, actual %0d", want.found, found);
         errors++;
      end
      if (offset !== want.offset) begin
         $error("match_offset mismatch: expected %0d, actual %0d", want.offset, offset);
         errors++;
      end
   endfunction
endclass

module wildcard_byte_pattern_scan_tb;
   import wbps_pkg::*;

   localparam int DEPTH          = PATTERN_MAX_DEFAULT;
   localparam int RANDOM_ITEMS   = 1550;
   localparam int SETTLE_CYCLES  = 6;
   localparam int FINAL_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_START     = 1500;
   localparam int HOLD_CYCLES    = 400;

   localparam int STALL_NONE        = 0;
   localparam int STALL_EVERY_THIRD = 1;
   localparam int STALL_RANDOM      = 2;
   localparam int STALL_BRIEF       = 3;
   localparam int STALL_LONG        = 4;

   logic                      clock;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_stall;
   logic                      req_cmd           = CMD_PATTERN;
   logic [PAT_INDEX_W-1:0]    req_pattern_index = '0;
   logic [BYTE_W-1:0]         req_pattern_byte  = '0;
   logic                      req_pattern_care  = 1'b0;
   logic [BYTE_W-1:0]         req_data_byte     = '0;
   logic                      req_data_last     = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall         = 1'b0;
   logic                      rsp_found;
   logic [MATCH_OFFSET_W-1:0] rsp_match_offset;
   logic                      csr_wr_en         = 1'b0;
   logic [LEN_W-1:0]          csr_wr_data       = '0;

   scan_scoreboard sb;
   int unsigned    items_sent      = 0;
   int unsigned    burst_left      = 0;
   int unsigned    backpressure    = 0;
   int unsigned    longest_pattern = 1;
   int unsigned    rx_cycles       = 0;
   bit             long_hold_done  = 1'b0;

   wildcard_byte_pattern_scan i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_pattern_index (req_pattern_index),
      .req_pattern_byte  (req_pattern_byte),
      .req_pattern_care  (req_pattern_care),
      .req_data_byte     (req_data_byte),
      .req_data_last     (req_data_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_found, rsp_match_offset);
      if (!reset && req_valid && req_stall)
         backpressure++;
   end

   // Sender pacing: bursts of random length, each followed by a gap that may be empty.
   task automatic pace();
      int unsigned gap;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_item(input scan_item_type it);
      req_valid         <= 1'b1;
      req_cmd           <= it.cmd;
      req_pattern_index <= it.pattern_index;
      req_pattern_byte  <= it.pattern_byte;
      req_pattern_care  <= it.pattern_care;
      req_data_byte     <= it.data_byte;
      req_data_last     <= it.data_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(it);
      items_sent++;
      pace();
   endtask

   // Fields that the command does not use carry random values.
   task automatic write_entry(input int unsigned index, input logic [7:0] value,
                              input logic care);
      scan_item_type it;
      it.cmd           = CMD_PATTERN;
      it.pattern_index = PAT_INDEX_W'(index);
      it.pattern_byte  = value;
      it.pattern_care  = care;
      it.data_byte     = 8'($urandom);
      it.data_last     = 1'($urandom);
      send_item(it);
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last);
      scan_item_type it;
      it.cmd           = CMD_DATA;
      it.pattern_index = PAT_INDEX_W'($urandom);
      it.pattern_byte  = 8'($urandom);
      it.pattern_care  = 1'($urandom);
      it.data_byte     = value;
      it.data_last     = last;
      send_item(it);
   endtask

   // Waits until every expected result is in and the pipeline has had time to empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_length(value);
      if (sb.active_length() > longest_pattern)
         longest_pattern = sb.active_length();
   endtask

   // One region: biased random bytes, usually with a full or damaged copy of the pattern.
   task automatic scan_region(input int unsigned used);
      int unsigned n_bytes, start, pick, j;
      logic [7:0]  region_bytes [$];
      pick = $urandom_range(0, 19);
      if (pick < 15)
         n_bytes = $urandom_range(1, used + 6);
      else if (pick < 19)
         n_bytes = $urandom_range(1, used);
      else
         n_bytes = $urandom_range(used, 3 * used + 10);
      for (int i = 0; i < n_bytes; i++)
         region_bytes.push_back($urandom_range(0, 1) ?
                                sb.entry_byte[$urandom_range(0, used - 1)] : 8'($urandom));
      if ($urandom_range(0, 9) < 7) begin
         start = $urandom_range(0, n_bytes - 1);
         for (j = 0; j < used && start + j < n_bytes; j++)
            region_bytes[start + j] = sb.entry_care[j] ? sb.entry_byte[j] : 8'($urandom);
         if ($urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, used - 1);
            if (start + j < n_bytes)
               region_bytes[start + j] ^= 8'(1 << $urandom_range(0, 7));
         end
      end
      for (int i = 0; i < n_bytes; i++) begin
         if ($urandom_range(0, 39) == 0)
            write_entry($urandom_range(0, DEPTH - 1), 8'($urandom), 1'($urandom));
         send_byte(region_bytes[i], i == n_bytes - 1);
      end
   endtask

   task automatic run_phase(input logic [LEN_W-1:0] value, input int unsigned random_end);
      int unsigned used, phase_end;
      write_length(value);
      used = sb.active_length();
      for (int k = 0; k < used; k++)
         write_entry(k, 8'($urandom), $urandom_range(0, 9) < 7);
      phase_end = items_sent + 120 + 3 * used;
      while (items_sent < phase_end && items_sent < random_end)
         scan_region(used);
   endtask

   // Receiver: stall patterns of its own, and one long hold-off so the block backs up.
   initial begin
      int unsigned mode, span;
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(STALL_NONE, STALL_BRIEF);
         span = (mode == STALL_BRIEF) ? $urandom_range(1, 10) : $urandom_range(8, 60);
         if (!long_hold_done && rx_cycles >= HOLD_START) begin
            mode = STALL_LONG;
            span = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         repeat (span) begin
            case (mode)
               STALL_NONE:        rsp_stall <= 1'b0;
               STALL_EVERY_THIRD: rsp_stall <= (rx_cycles % 3 == 0);
               STALL_RANDOM:      rsp_stall <= 1'($urandom);
               default:           rsp_stall <= 1'b1;
            endcase
            @(posedge clock);
            rx_cycles++;
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int unsigned random_end, phase;
      int unsigned length_plan [12];
      length_plan = '{1, 2, 3, 0, 5, 8, 127, 4, 2, 64, 6, 1};
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every entry gets written once so no region ever reads an unwritten one.
      for (int k = 0; k < DEPTH; k++)
         write_entry(k, 8'($urandom), 1'($urandom));

      // Directed: extremes, wildcards, late matches, mid-region updates.
      write_entry(0, 8'h00, 1'b1);
      write_entry(1, 8'hFF, 1'b1);
      write_entry(2, 8'hA5, 1'b0);
      write_entry(DEPTH - 1, 8'hFF, 1'b1);
      write_length(0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      write_length(3);
      // Match at offset one, then a trailing byte that only rearms.
      send_byte(8'h12, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'h00, 1'b1);
      // Match that ends on the final byte of the region.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
      // Region shorter than the pattern.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // Pattern entry replaced while a partial match is in flight.
      send_byte(8'h00, 1'b0);
      write_entry(1, 8'h11, 1'b1);
      send_byte(8'h11, 1'b0);
      send_byte(8'hFF, 1'b1);
      // Length shortened mid-region keeps the partial match.
      send_byte(8'h00, 1'b0);
      write_length(2);
      send_byte(8'h11, 1'b1);
      write_length(127);
      send_byte(8'h00, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'hFF, 1'b1);

      random_end = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < random_end) begin
         run_phase(phase < 12 ? LEN_W'(length_plan[phase]) : LEN_W'($urandom_range(1, 12)),
                   random_end);
         phase++;
      end

      settle();
      repeat (FINAL_CYCLES) @(posedge clock);
      $display("Scanned %0d regions in %0d items: %0d matches, %0d not found.",
               sb.regions, items_sent, sb.matched, sb.misses);
      $display("Pattern lengths up to %0d; input stalled on %0d cycles.",
               longest_pattern, backpressure);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
